// ----- rtl/assert_macros.svh -----
// Assertion macros for the rotation matrix RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked property, masked while reset is asserted.
`define AARM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked property that also holds while reset is asserted.
`define AARM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define AARM_ASSERT(lbl, prop, msg)
`define AARM_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- rtl/aarm_pkg.sv -----
// Shared types, constants and tables for the axis-angle rotation matrix core.
package aarm_pkg;

  // Field formats.
  localparam int FRAC_BITS        = 14;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int IN_W             = 16;
  localparam int OUT_W            = 17;

  // Internal formats; the angle, CORDIC and k values carry 30 fraction bits.
  localparam int INT_FRAC = 30;
  localparam int TH_W     = 36;
  localparam int Z_W      = 34;
  localparam int X_W      = 34;
  localparam int K_W      = 35;
  localparam int AA_W     = 2 * IN_W;
  localparam int PROD_W   = AA_W + K_W;
  localparam int ACC_W    = 56;

  localparam logic signed [TH_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [TH_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [TH_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [X_W-1:0]  GAIN_Q30    = 34'sd652032874;
  localparam logic signed [K_W-1:0]  ONE_Q30     = 35'sd1073741824;

  // Rounding offsets and output saturation bound.
  localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0]  ACC_HALF  = ACC_W'(1) << (INT_FRAC - 1);
  localparam int LIMIT_RAW = 3 * (1 << FRAC_BITS);
  localparam logic signed [ACC_W-1:0]  OUT_LIMIT =
    ACC_W'((LIMIT_RAW > 65535) ? 65535 : LIMIT_RAW);

  // Axis components riding alongside the angle.
  typedef struct packed {
    logic signed [IN_W-1:0] ax;
    logic signed [IN_W-1:0] ay;
    logic signed [IN_W-1:0] az;
    logic                   neg;
  } side_t;

  typedef struct packed {
    logic                  valid;
    logic signed [Z_W-1:0] z;
    side_t                 side;
  } cordic_in_t;

  typedef struct packed {
    logic                  valid;
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] y;
    side_t                 side;
  } cordic_out_t;

  // Arctangent of 2^-idx with 30 fraction bits.
  function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0:  v = 34'sh3243F6A8;
      1:  v = 34'sh1DAC6705;
      2:  v = 34'sh0FADBAFC;
      3:  v = 34'sh07F56EA6;
      4:  v = 34'sh03FEAB76;
      5:  v = 34'sh01FFD55B;
      6:  v = 34'sh00FFFAAA;
      7:  v = 34'sh007FFF55;
      8:  v = 34'sh003FFFEA;
      9:  v = 34'sh001FFFFD;
      10: v = 34'sh000FFFFF;
      11: v = 34'sh0007FFFF;
      12: v = 34'sh0003FFFF;
      13: v = 34'sh0001FFFF;
      14: v = 34'sh0000FFFF;
      15: v = 34'sh00007FFF;
      16: v = 34'sh00003FFF;
      17: v = 34'sh00001FFF;
      18: v = 34'sh00000FFF;
      19: v = 34'sh000007FF;
      20: v = 34'sh000003FF;
      21: v = 34'sh000001FF;
      22: v = 34'sh000000FF;
      23: v = 34'sh0000007F;
      24: v = 34'sh0000003F;
      25: v = 34'sh0000001F;
      26: v = 34'sh0000000F;
      27: v = 34'sh00000008;
      28: v = 34'sh00000004;
      29: v = 34'sh00000002;
      30: v = 34'sh00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round a product to 44 fraction bits: add one half, then floor.
  function automatic logic signed [ACC_W-1:0] round_prod(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = (p + PROD_HALF) >>> FRAC_BITS;
    return t[ACC_W-1:0];
  endfunction

endpackage

// ----- rtl/aarm_cordic.sv -----
// Pipelined rotation-mode CORDIC, one micro-rotation per register stage.
module aarm_cordic #(
  parameter int CordicSteps = aarm_pkg::CORDIC_STEPS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  aarm_pkg::cordic_in_t   cin_i,
  output aarm_pkg::cordic_out_t  cout_o
);

  localparam int XW = aarm_pkg::X_W;
  localparam int ZW = aarm_pkg::Z_W;

  logic                 vld_q  [CordicSteps];
  logic signed [XW-1:0] x_q    [CordicSteps];
  logic signed [XW-1:0] y_q    [CordicSteps];
  logic signed [ZW-1:0] z_q    [CordicSteps];
  aarm_pkg::side_t      side_q [CordicSteps];

  for (genvar i = 0; i < CordicSteps; i++) begin : g_stage
    logic                 vld_in;
    logic signed [XW-1:0] x_in, y_in, x_d, y_d;
    logic signed [ZW-1:0] z_in, z_d;
    aarm_pkg::side_t      side_in;

    // Stage input: the reduced angle for the first stage, the previous stage otherwise.
    if (i == 0) begin : g_first
      assign vld_in  = cin_i.valid;
      assign x_in    = aarm_pkg::GAIN_Q30;
      assign y_in    = '0;
      assign z_in    = cin_i.z;
      assign side_in = cin_i.side;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign x_in    = x_q[i-1];
      assign y_in    = y_q[i-1];
      assign z_in    = z_q[i-1];
      assign side_in = side_q[i-1];
    end

    // One micro-rotation toward zero residual angle.
    always_comb begin
      if (z_in >= 0) begin
        x_d = x_in - (y_in >>> i);
        y_d = y_in + (x_in >>> i);
        z_d = z_in - aarm_pkg::atan_q30(i);
      end else begin
        x_d = x_in + (y_in >>> i);
        y_d = y_in - (x_in >>> i);
        z_d = z_in + aarm_pkg::atan_q30(i);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i]    <= x_d;
        y_q[i]    <= y_d;
        z_q[i]    <= z_d;
        side_q[i] <= side_in;
      end
    end
  end

  assign cout_o.valid = vld_q[CordicSteps-1];
  assign cout_o.x     = x_q[CordicSteps-1];
  assign cout_o.y     = y_q[CordicSteps-1];
  assign cout_o.side  = side_q[CordicSteps-1];

endmodule

// ----- rtl/axis_angle_rotation_matrix_core.sv -----
// Top level: axis and angle in, nine rotation matrix entries out, fully pipelined.
//
//  channel | signals                                  | handshake
//  --------+------------------------------------------+--------------------------
//  in      | axis_x_i, axis_y_i, axis_z_i, angle_i    | in_valid_i / in_ready_o
//  out     | out_r1c1_o .. out_r3c3_o                 | out_valid_o / out_ready_i
//
// The pipeline holds two angle reduction stages, one CORDIC stage per
// micro-rotation and four product stages.
// A new item is taken every cycle while the output is free or being taken.
// A stalled output freezes every stage together; nothing is dropped or repeated.
// Reset clears only the stage valid bits.
`include "assert_macros.svh"
module axis_angle_rotation_matrix_core #(
  parameter int CORDIC_STEPS = aarm_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [15:0] axis_x_i,
  input  logic signed [15:0] axis_y_i,
  input  logic signed [15:0] axis_z_i,
  input  logic signed [15:0] angle_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [16:0] out_r1c1_o,
  output logic signed [16:0] out_r1c2_o,
  output logic signed [16:0] out_r1c3_o,
  output logic signed [16:0] out_r2c1_o,
  output logic signed [16:0] out_r2c2_o,
  output logic signed [16:0] out_r2c3_o,
  output logic signed [16:0] out_r3c1_o,
  output logic signed [16:0] out_r3c2_o,
  output logic signed [16:0] out_r3c3_o
);

  localparam int THW  = aarm_pkg::TH_W;
  localparam int ZW   = aarm_pkg::Z_W;
  localparam int XW   = aarm_pkg::X_W;
  localparam int KW   = aarm_pkg::K_W;
  localparam int AAW  = aarm_pkg::AA_W;
  localparam int PW   = aarm_pkg::PROD_W;
  localparam int ACW  = aarm_pkg::ACC_W;
  localparam int IW   = aarm_pkg::IN_W;
  localparam int OW   = aarm_pkg::OUT_W;

  // Largest magnitude an output entry may take.
  localparam logic signed [OW-1:0] OUT_MAX = OW'(aarm_pkg::OUT_LIMIT);

  // The whole pipeline advances unless a finished item is waiting.
  logic en;
  logic out_valid_q;
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;

  // Valid bits of the stages outside the CORDIC.
  logic r1_vld_q, r2_vld_q, p1_vld_q, p2_vld_q, p3_vld_q;

  // Stage 1: scale the angle to 30 fraction bits and wrap into plus or minus pi.
  logic signed [THW-1:0] theta, r1_d;
  logic signed [THW-1:0] r1_q;
  aarm_pkg::side_t       r1_side_q;

  assign theta = THW'(angle_i) <<< (aarm_pkg::INT_FRAC - (aarm_pkg::FRAC_BITS - 1));

  always_comb begin
    if (theta > aarm_pkg::PI_Q30) begin
      r1_d = theta - aarm_pkg::TWO_PI_Q30;
    end else if (theta < -aarm_pkg::PI_Q30) begin
      r1_d = theta + aarm_pkg::TWO_PI_Q30;
    end else begin
      r1_d = theta;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_q          <= r1_d;
      r1_side_q.ax  <= axis_x_i;
      r1_side_q.ay  <= axis_y_i;
      r1_side_q.az  <= axis_z_i;
      r1_side_q.neg <= 1'b0;
    end
  end

  // Stage 2: fold by pi into plus or minus pi/2 and note the sign flip.
  logic signed [THW-1:0] r2_d;
  logic                  neg_d;
  logic signed [ZW-1:0]  r2_q;
  aarm_pkg::side_t       r2_side_q;

  always_comb begin
    neg_d = 1'b0;
    r2_d  = r1_q;
    if (r1_q > aarm_pkg::HALF_PI_Q30) begin
      r2_d  = r1_q - aarm_pkg::PI_Q30;
      neg_d = 1'b1;
    end else if (r1_q < -aarm_pkg::HALF_PI_Q30) begin
      r2_d  = r1_q + aarm_pkg::PI_Q30;
      neg_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_q          <= r2_d[ZW-1:0];
      r2_side_q.ax  <= r1_side_q.ax;
      r2_side_q.ay  <= r1_side_q.ay;
      r2_side_q.az  <= r1_side_q.az;
      r2_side_q.neg <= neg_d;
    end
  end

  // CORDIC pipeline.
  aarm_pkg::cordic_in_t  cin;
  aarm_pkg::cordic_out_t cout;

  assign cin.valid = r2_vld_q;
  assign cin.z     = r2_q;
  assign cin.side  = r2_side_q;

  aarm_cordic #(
    .CordicSteps(CORDIC_STEPS)
  ) u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .cin_i (cin),
    .cout_o(cout)
  );

  // Stage P1: cosine, sine, k = 1 - cos, and the axis component products.
  logic signed [XW-1:0]  c_d, s_d;
  logic signed [XW-1:0]  c_q, s_q;
  logic signed [KW-1:0]  k_q;
  logic signed [AAW-1:0] aa_q [6];
  logic signed [IW-1:0]  a_q  [3];

  assign c_d = cout.side.neg ? -cout.x : cout.x;
  assign s_d = cout.side.neg ? -cout.y : cout.y;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q     <= c_d;
      s_q     <= s_d;
      k_q     <= aarm_pkg::ONE_Q30 - KW'(c_d);
      aa_q[0] <= AAW'(cout.side.ax) * AAW'(cout.side.ax);
      aa_q[1] <= AAW'(cout.side.ay) * AAW'(cout.side.ay);
      aa_q[2] <= AAW'(cout.side.az) * AAW'(cout.side.az);
      aa_q[3] <= AAW'(cout.side.ax) * AAW'(cout.side.ay);
      aa_q[4] <= AAW'(cout.side.ax) * AAW'(cout.side.az);
      aa_q[5] <= AAW'(cout.side.ay) * AAW'(cout.side.az);
      a_q[0]  <= cout.side.ax;
      a_q[1]  <= cout.side.ay;
      a_q[2]  <= cout.side.az;
    end
  end

  // Stage P2: scale the products by k, the axis by sin, and lift cos to 44 fraction bits.
  logic signed [PW-1:0]  prod_q [6];
  logic signed [ACW-1:0] as_q   [3];
  logic signed [ACW-1:0] cf_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        prod_q[i] <= PW'(aa_q[i]) * PW'(k_q);
      end
      for (int i = 0; i < 3; i++) begin
        as_q[i] <= ACW'(a_q[i]) * ACW'(s_q);
      end
      cf_q <= ACW'(c_q) <<< aarm_pkg::FRAC_BITS;
    end
  end

  // Stage P3: round each product and add the cosine or signed sine term.
  logic signed [ACW-1:0] rp [6];
  logic signed [ACW-1:0] acc_q [9];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      rp[i] = aarm_pkg::round_prod(prod_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      acc_q[0] <= rp[0] + cf_q;
      acc_q[1] <= rp[3] - as_q[2];
      acc_q[2] <= rp[4] + as_q[1];
      acc_q[3] <= rp[3] + as_q[2];
      acc_q[4] <= rp[1] + cf_q;
      acc_q[5] <= rp[5] - as_q[0];
      acc_q[6] <= rp[4] - as_q[1];
      acc_q[7] <= rp[5] + as_q[0];
      acc_q[8] <= rp[2] + cf_q;
    end
  end

  // Stage P4: round to 14 fraction bits and saturate into the output register.
  logic signed [ACW-1:0] rs  [9];
  logic signed [OW-1:0]  sat [9];
  logic signed [OW-1:0]  out_q [9];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      rs[i] = (acc_q[i] + aarm_pkg::ACC_HALF) >>> aarm_pkg::INT_FRAC;
      if (rs[i] > aarm_pkg::OUT_LIMIT) begin
        sat[i] = aarm_pkg::OUT_LIMIT[OW-1:0];
      end else if (rs[i] < -aarm_pkg::OUT_LIMIT) begin
        sat[i] = -aarm_pkg::OUT_LIMIT[OW-1:0];
      end else begin
        sat[i] = rs[i][OW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        out_q[i] <= sat[i];
      end
    end
  end

  // Valid bits move with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_vld_q    <= 1'b0;
      r2_vld_q    <= 1'b0;
      p1_vld_q    <= 1'b0;
      p2_vld_q    <= 1'b0;
      p3_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      r1_vld_q    <= in_valid_i;
      r2_vld_q    <= r1_vld_q;
      p1_vld_q    <= cout.valid;
      p2_vld_q    <= p1_vld_q;
      p3_vld_q    <= p2_vld_q;
      out_valid_q <= p3_vld_q;
    end
  end

  assign out_r1c1_o = out_q[0];
  assign out_r1c2_o = out_q[1];
  assign out_r1c3_o = out_q[2];
  assign out_r2c1_o = out_q[3];
  assign out_r2c2_o = out_q[4];
  assign out_r2c3_o = out_q[5];
  assign out_r3c1_o = out_q[6];
  assign out_r3c2_o = out_q[7];
  assign out_r3c3_o = out_q[8];

  // Checks on the pipeline control and the saturation.
  `AARM_ASSERT_RST(a_rst_empty, !rst_ni |-> !out_valid_o, "output valid during reset")
  `AARM_ASSERT(a_stall_blocks, out_valid_o && !out_ready_i |-> !in_ready_o, "took item in stall")
  `AARM_ASSERT(a_r1c1_sat, out_valid_o |-> (out_r1c1_o <= OUT_MAX && out_r1c1_o >= -OUT_MAX), "r1c1")
  `AARM_ASSERT(a_r3c3_sat, out_valid_o |-> (out_r3c3_o <= OUT_MAX && out_r3c3_o >= -OUT_MAX), "r3c3")

endmodule
